// ----- sv/crt_two_moduli_solver_core_defines.svh -----
// ---------------------------------------------------------------------------
// CRT solver assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef CRT_TWO_MODULI_SOLVER_CORE_DEFINES_SVH
`define CRT_TWO_MODULI_SOLVER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CRT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CRT_ASSERT(lbl, prop, msg)
`define CRT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/crt_pkg.sv -----
// ---------------------------------------------------------------------------
// CRT solver package
// Shared types for the sequencer and the iterative arithmetic unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package crt_pkg;

  localparam int unsigned DW = 64;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } crt_op_e;

  typedef struct packed {
    logic    start;
    crt_op_e op;
    logic    short_len;
  } crt_req_t;

  typedef struct packed {
    logic done;
  } crt_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EUC,
    ST_EUC_W,
    ST_DIFF_W,
    ST_N_W,
    ST_M_W,
    ST_U_W,
    ST_V_W,
    ST_UV_W,
    ST_T_W,
    ST_P_W,
    ST_B_W,
    ST_SUM,
    ST_R_W
  } crt_state_e;

endpackage

// ----- sv/crt_two_moduli_solver_core.sv -----
// ---------------------------------------------------------------------------
// CRT two-moduli solver core
// Merges x = b1 mod m1 and x = b2 mod m2 into x = r mod lcm(m1, m2).
// ---------------------------------------------------------------------------
// Usage: drive the four operand ports and raise start while busy is low;
// the request is taken at that edge and busy rises the next cycle unless a
// modulus is zero. done_o is high for exactly one cycle with solvable_o,
// combined_residue_o and combined_modulus_o; the receiver must take the
// result then, it cannot stall the core. Unsolvable requests return zeros.
// A zero modulus gives done_o in the cycle after the request.
// Otherwise each extended Euclid step is one half-width divide on the shared
// bit-serial unit, issued and handed over by the sequencer (1 to 45 steps).
// An unsolvable pair ends after one full-width divide. A solvable pair adds
// five full-width divides, one half-width divide and three half-width
// multiplies, each followed by a hand-over. One request is in flight at a
// time; busy falls as done_o rises, so the next request can be taken at the
// edge that takes the result.
// Reset clears the sequencer and the result strobe; no memory to clear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "crt_two_moduli_solver_core_defines.svh"

module crt_two_moduli_solver_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_residue_i,
  input  logic        [30:0] first_modulus_i,
  input  logic signed [31:0] second_residue_i,
  input  logic        [30:0] second_modulus_i,
  output logic               done_o,
  output logic               solvable_o,
  output logic        [61:0] combined_residue_o,
  output logic        [61:0] combined_modulus_o
);
  import crt_pkg::*;

  crt_state_e state_q, state_d;
  crt_req_t   req;
  crt_sts_t   sts;
  logic [DW-1:0] ux, uy, udv, quo, rem, acc;

  logic [31:0] b1_q, b1_d, b2_q, b2_d;
  logic [30:0] m1_q, m1_d, m2_q, m2_d, ra_q, ra_d, rb_q, rb_d;
  logic [33:0] sa_q, sa_d, sb_q, sb_d;
  logic        neg_q, neg_d;
  logic [32:0] qm_q, qm_d;
  logic [30:0] n_q, n_d, u_q, u_d;
  logic [61:0] m_q, m_d, p_q, p_d, base_q, base_d;
  logic        done_q, done_d, solv_q, solv_d;
  logic [61:0] res_q, res_d, mod_q, mod_d;

  logic [32:0] diff;
  logic [32:0] diff_mag;
  logic [33:0] sa_mag;
  logic [30:0] r31;
  logic [61:0] r62;
  logic        mods_nz, res_zero, res_below;

  always_comb begin
    diff     = {b2_q[31], b2_q} - {b1_q[31], b1_q};
    diff_mag = diff[32] ? (33'd0 - diff) : diff;
    sa_mag   = sa_q[33] ? (34'd0 - sa_q) : sa_q;
    r31      = rem[30:0];
    r62      = rem[61:0];
  end

  always_comb begin
    state_d = state_q;
    req     = '{start: 1'b0, op: OP_DIV, short_len: 1'b0};
    ux      = '0;
    uy      = '0;
    udv     = '0;
    b1_d    = b1_q;
    b2_d    = b2_q;
    m1_d    = m1_q;
    m2_d    = m2_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    neg_d   = neg_q;
    qm_d    = qm_q;
    n_d     = n_q;
    u_d     = u_q;
    m_d     = m_q;
    p_d     = p_q;
    base_d  = base_q;
    done_d  = 1'b0;
    solv_d  = solv_q;
    res_d   = res_q;
    mod_d   = mod_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          b1_d = first_residue_i;
          b2_d = second_residue_i;
          m1_d = first_modulus_i;
          m2_d = second_modulus_i;
          ra_d = first_modulus_i;
          rb_d = second_modulus_i;
          sa_d = 34'd1;
          sb_d = '0;
          if (first_modulus_i == '0 || second_modulus_i == '0) begin
            done_d = 1'b1;
            solv_d = 1'b0;
            res_d  = '0;
            mod_d  = '0;
          end else begin
            state_d = ST_EUC;
          end
        end
      end
      ST_EUC: begin
        req.start = 1'b1;
        if (rb_q == '0) begin
          neg_d   = diff[32];
          ux      = {31'd0, diff_mag};
          udv     = {33'd0, ra_q};
          state_d = ST_DIFF_W;
        end else begin
          req.short_len = 1'b1;
          ux      = {33'd0, ra_q};
          udv     = {33'd0, rb_q};
          uy      = {{(DW-34){sb_q[33]}}, sb_q};
          state_d = ST_EUC_W;
        end
      end
      ST_EUC_W: begin
        if (sts.done) begin
          ra_d    = rb_q;
          rb_d    = r31;
          sa_d    = sb_q;
          sb_d    = sa_q - acc[33:0];
          state_d = ST_EUC;
        end
      end
      ST_DIFF_W: begin
        if (sts.done) begin
          if (rem != '0) begin
            done_d  = 1'b1;
            solv_d  = 1'b0;
            res_d   = '0;
            mod_d   = '0;
            state_d = ST_IDLE;
          end else begin
            qm_d          = quo[32:0];
            req.start     = 1'b1;
            req.short_len = 1'b1;
            ux            = {33'd0, m2_q};
            udv           = {33'd0, ra_q};
            state_d       = ST_N_W;
          end
        end
      end
      ST_N_W: begin
        if (sts.done) begin
          n_d           = quo[30:0];
          req.start     = 1'b1;
          req.op        = OP_MUL;
          req.short_len = 1'b1;
          ux            = {33'd0, quo[30:0]};
          uy            = {33'd0, m1_q};
          state_d       = ST_M_W;
        end
      end
      ST_M_W: begin
        if (sts.done) begin
          m_d       = acc[61:0];
          req.start = 1'b1;
          ux        = {31'd0, qm_q};
          udv       = {33'd0, n_q};
          state_d   = ST_U_W;
        end
      end
      ST_U_W: begin
        if (sts.done) begin
          u_d       = (neg_q && r31 != '0) ? (n_q - r31) : r31;
          req.start = 1'b1;
          ux        = {30'd0, sa_mag};
          udv       = {33'd0, n_q};
          state_d   = ST_V_W;
        end
      end
      ST_V_W: begin
        if (sts.done) begin
          req.start     = 1'b1;
          req.op        = OP_MUL;
          req.short_len = 1'b1;
          ux            = {33'd0, u_q};
          uy            = {33'd0, ((sa_q[33] && r31 != '0) ? (n_q - r31) : r31)};
          state_d       = ST_UV_W;
        end
      end
      ST_UV_W: begin
        if (sts.done) begin
          req.start = 1'b1;
          ux        = acc;
          udv       = {33'd0, n_q};
          state_d   = ST_T_W;
        end
      end
      ST_T_W: begin
        if (sts.done) begin
          req.start     = 1'b1;
          req.op        = OP_MUL;
          req.short_len = 1'b1;
          ux            = {33'd0, r31};
          uy            = {33'd0, m1_q};
          state_d       = ST_P_W;
        end
      end
      ST_P_W: begin
        if (sts.done) begin
          p_d       = acc[61:0];
          req.start = 1'b1;
          ux        = {32'd0, (b1_q[31] ? (32'd0 - b1_q) : b1_q)};
          udv       = {2'd0, m_q};
          state_d   = ST_B_W;
        end
      end
      ST_B_W: begin
        if (sts.done) begin
          base_d  = (b1_q[31] && r62 != '0) ? (m_q - r62) : r62;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        req.start = 1'b1;
        ux        = {2'd0, base_q} + {2'd0, p_q};
        udv       = {2'd0, m_q};
        state_d   = ST_R_W;
      end
      ST_R_W: begin
        if (sts.done) begin
          done_d  = 1'b1;
          solv_d  = 1'b1;
          res_d   = r62;
          mod_d   = m_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q   <= b1_d;
    b2_q   <= b2_d;
    m1_q   <= m1_d;
    m2_q   <= m2_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    neg_q  <= neg_d;
    qm_q   <= qm_d;
    n_q    <= n_d;
    u_q    <= u_d;
    m_q    <= m_d;
    p_q    <= p_d;
    base_q <= base_d;
    solv_q <= solv_d;
    res_q  <= res_d;
    mod_q  <= mod_d;
  end

  crt_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .x_i    (ux),
    .y_i    (uy),
    .dvsr_i (udv),
    .sts_o  (sts),
    .quo_o  (quo),
    .rem_o  (rem),
    .acc_o  (acc)
  );

  assign busy               = (state_q != ST_IDLE);
  assign done_o             = done_q;
  assign solvable_o         = solv_q;
  assign combined_residue_o = res_q;
  assign combined_modulus_o = mod_q;

  assign mods_nz   = (first_modulus_i != '0) && (second_modulus_i != '0);
  assign res_zero  = (combined_residue_o == '0) && (combined_modulus_o == '0);
  assign res_below = (combined_residue_o < combined_modulus_o);

  `CRT_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  `CRT_ASSERT(a_start_busy, start && !busy && mods_nz |=> busy, "request not taken")
  `CRT_ASSERT(a_fail_zero, done_o && !solvable_o |-> res_zero, "nonzero fail result")
  `CRT_ASSERT(a_res_range, done_o && solvable_o |-> res_below, "residue not below modulus")

endmodule

// ----- sv/crt_iter_unit.sv -----
// ---------------------------------------------------------------------------
// CRT iterative unit
// Bit-serial restoring divider and shift-add multiplier, one bit per cycle,
// with a Horner accumulator that sums quotient times y during a divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crt_iter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  crt_pkg::crt_req_t          req_i,
  input  logic [crt_pkg::DW-1:0]     x_i,
  input  logic [crt_pkg::DW-1:0]     y_i,
  input  logic [crt_pkg::DW-1:0]     dvsr_i,
  output crt_pkg::crt_sts_t          sts_o,
  output logic [crt_pkg::DW-1:0]     quo_o,
  output logic [crt_pkg::DW-1:0]     rem_o,
  output logic [crt_pkg::DW-1:0]     acc_o
);
  import crt_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);
  localparam int unsigned HW = DW / 2;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  crt_op_e       op_q;
  logic [DW-1:0] x_q, y_q, dvsr_q, rem_q, quo_q, acc_q;
  logic [DW-1:0] rem_sh, rem_n, acc_n;
  logic          ge, bit_s;

  always_comb begin
    rem_sh = {rem_q[DW-2:0], x_q[DW-1]};
    ge     = (rem_sh >= dvsr_q);
    rem_n  = ge ? (rem_sh - dvsr_q) : rem_sh;
    bit_s  = (op_q == OP_DIV) ? ge : x_q[DW-1];
    acc_n  = {acc_q[DW-2:0], 1'b0} + (bit_s ? y_q : '0);
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = req_i.short_len ? CW'(HW) : CW'(DW);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q   <= req_i.op;
      x_q    <= req_i.short_len ? {x_i[HW-1:0], {HW{1'b0}}} : x_i;
      y_q    <= y_i;
      dvsr_q <= dvsr_i;
      rem_q  <= '0;
      quo_q  <= '0;
      acc_q  <= '0;
    end else if (cnt_q != '0) begin
      x_q   <= {x_q[DW-2:0], 1'b0};
      acc_q <= acc_n;
      if (op_q == OP_DIV) begin
        rem_q <= rem_n;
        quo_q <= {quo_q[DW-2:0], ge};
      end
    end
  end

  assign sts_o.done = done_q;
  assign quo_o      = quo_q;
  assign rem_o      = rem_q;
  assign acc_o      = acc_q;

endmodule

// ----- tb/crt_two_moduli_solver_core_tb.sv -----
// ---------------------------------------------------------------------------
// CRT two-moduli solver core testbench
// Sends pairs of congruences with random gaps, predicts each merged result
// with an extended Euclid model and checks every done_o strobe against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic        solvable;
  logic [61:0] residue;
  logic [61:0] modulus;
} crt_result_t;

class crt_result_board;
  crt_result_t pending[$];
  int unsigned errors;
  int unsigned checked;

  function longint wrap(longint a, longint n);
    longint t;
    t = a % n;
    if (t < 0) t += n;
    return t;
  endfunction

  function void note_request(logic signed [31:0] b1, logic [30:0] m1,
                             logic signed [31:0] b2, logic [30:0] m2);
    crt_result_t e;
    longint ra, rb, sa, sb, q, tr, ts, d, diff, n, m, u, v, t, base;
    e.solvable = 1'b0;
    e.residue  = '0;
    e.modulus  = '0;
    if (m1 != 0 && m2 != 0) begin
      ra = m1; rb = m2; sa = 1; sb = 0;
      while (rb != 0) begin
        q = ra / rb;
        tr = ra - q * rb;
        ts = sa - q * sb;
        ra = rb; rb = tr; sa = sb; sb = ts;
      end
      d = ra;
      diff = longint'(b2) - longint'(b1);
      if (diff % d == 0) begin
        n = m2 / d;
        m = longint'(m1) * n;
        u = wrap(diff / d, n);
        v = wrap(sa, n);
        t = (u * v) % n;
        base = wrap(longint'(b1), m);
        e.solvable = 1'b1;
        e.residue  = 62'((base + longint'(m1) * t) % m);
        e.modulus  = 62'(m);
      end
    end
    pending.push_back(e);
  endfunction

  function void check_result(logic solvable, logic [61:0] residue, logic [61:0] modulus);
    crt_result_t e;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result %0b %0d %0d", solvable, residue,
                                 modulus);
      return;
    end
    e = pending.pop_front();
    if (e.solvable !== solvable || e.residue !== residue || e.modulus !== modulus) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: expected %0b %0d %0d, got %0b %0d %0d", e.solvable, e.residue,
                 e.modulus, solvable, residue, modulus);
    end
  endfunction
endclass

module crt_two_moduli_solver_core_tb;
  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] first_residue_i;
  logic        [30:0] first_modulus_i;
  logic signed [31:0] second_residue_i;
  logic        [30:0] second_modulus_i;
  logic               done_o;
  logic               solvable_o;
  logic        [61:0] combined_residue_o;
  logic        [61:0] combined_modulus_o;

  crt_result_board board;
  int unsigned     sent;

  crt_two_moduli_solver_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(solvable_o, combined_residue_o, combined_modulus_o);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic signed [31:0] b1, logic [30:0] m1,
                              logic signed [31:0] b2, logic [30:0] m2);
    bit taken;
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    first_residue_i  = b1;
    first_modulus_i  = m1;
    second_residue_i = b2;
    second_modulus_i = m2;
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      if (!busy) begin
        taken = 1'b1;
        board.note_request(b1, m1, b2, m2);
        sent++;
      end
      @(negedge clk_i);
    end
  endtask

  task automatic send_random();
    logic [30:0] g, a, b;
    logic signed [31:0] b1, b2;
    b1 = $urandom;
    b2 = $urandom;
    case ($urandom_range(0, 5))
      0: begin
        send_request(b1, 31'($urandom), b2, 31'($urandom));
      end
      1: begin
        send_request(b1, 31'($urandom_range(1, 40)), b2, 31'($urandom_range(1, 40)));
      end
      2, 3: begin
        g = 31'($urandom_range(1, 1000));
        a = 31'($urandom_range(1, 2000000));
        b = 31'($urandom_range(1, 2000000));
        b2 = b1 + 32'(g) * 32'($urandom_range(0, 1000));
        if ($urandom_range(0, 3) == 0) b2 = b2 + 32'sd1;
        send_request(b1, g * a, b2, g * b);
      end
      4: begin
        g = 31'($urandom) | 31'h4000_0000;
        send_request(b1, g, b1, g - 31'($urandom_range(0, 3)));
      end
      default: begin
        send_request(b1, ($urandom_range(0, 9) == 0) ? 31'd0 : 31'($urandom), b2,
                     ($urandom_range(0, 9) == 0) ? 31'd0 : 31'($urandom_range(1, 5000)));
      end
    endcase
  endtask

  initial begin
    board = new();
    sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    first_residue_i  = '0;
    first_modulus_i  = '0;
    second_residue_i = '0;
    second_modulus_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(32'sd0, 31'd1, 32'sd0, 31'd1);
    send_request(32'sd5, 31'd0, 32'sd3, 31'd7);
    send_request(32'sd5, 31'd7, 32'sd3, 31'd0);
    send_request(32'sd0, 31'd0, 32'sd0, 31'd0);
    send_request(32'sd2, 31'd3, 32'sd3, 31'd5);
    send_request(32'sd1, 31'd4, 32'sd3, 31'd6);
    send_request(32'sd1, 31'd4, 32'sd2, 31'd6);
    send_request(-32'sd7, 31'd9, 32'sd7, 31'd9);
    send_request(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFE);
    send_request(32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_request(-32'sd1, 31'h7FFF_FFFF, -32'sd1, 31'd1);
    send_request(32'sh8000_0000, 31'd1, 32'sh7FFF_FFFF, 31'd2);
    send_request(32'sd12345, 31'd1836311903, -32'sd999, 31'd1134903170);
    send_request(-32'sd1, 31'h4000_0000, 32'sd3, 31'h2000_0000);
    send_request(32'sd0, 31'h5555_5555, -32'sd1, 31'h2AAA_AAAA);

    repeat (354) send_random();
    start = 1'b0;

    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d results, covering zero moduli,", sent,
             board.checked);
    $display("coprime, shared-factor and unsolvable pairs; %0d mismatches.", board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+sv
sv/crt_pkg.sv
sv/crt_iter_unit.sv
sv/crt_two_moduli_solver_core.sv
tb/crt_two_moduli_solver_core_tb.sv
